// ===== sv/vcfcp_pkg.sv =====
// vcfcp_pkg: shared types and constants of the virtual-channel frame capture packer.
// Holds the input and result transaction structs. No dependencies.
package vcfcp_pkg;

    localparam int NUM_CH        = 4;
    localparam int CH_W          = 2;
    localparam int HALF_W        = 16;
    localparam int WORD_W        = 32;
    localparam int WORD_INDEX_W  = 10;
    localparam int FRAME_WORDS_W = 11;

    typedef struct packed {
        logic              reset_request;
        logic [NUM_CH-1:0] valid_mask;
        logic [NUM_CH-1:0] sof_mask;
        logic [NUM_CH-1:0] eof_mask;
        logic [NUM_CH-1:0] eofe_mask;
        logic [HALF_W-1:0] data_ch0;
        logic [HALF_W-1:0] data_ch1;
        logic [HALF_W-1:0] data_ch2;
        logic [HALF_W-1:0] data_ch3;
    } t_in_item;

    typedef struct packed {
        logic [NUM_CH-1:0]        ready_mask;
        logic                     sof_error;
        logic                     word_valid;
        logic [WORD_INDEX_W-1:0]  word_index;
        logic [WORD_W-1:0]        word_data;
        logic                     frame_done;
        logic [CH_W-1:0]          frame_channel;
        logic [FRAME_WORDS_W-1:0] frame_words;
        logic                     frame_error;
    } t_out_item;

endpackage

// ===== sv/vc_frame_capture_packer.sv =====
// Four-channel frame capture mux: while idle it grants the lowest-numbered valid channel
// (flagging a missing start-of-frame), then packs that channel's halfwords low-first into
// 32-bit words with their index and reports channel, whole-word count and error at end of
// frame. Every transaction in gives exactly one result transaction. Throughput is one
// transaction per clock while o_stall is low. The result side is a result register plus
// one skid entry, so o_stall rises only after two results are held back by i_stall.
// Frame length is capped at FRAME_WORDS_MAX words; halfwords beyond that are dropped.
// Depends on vcfcp_pkg and vcfcp_skid.
module vc_frame_capture_packer #(
    parameter int FRAME_WORDS_MAX = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  vcfcp_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output vcfcp_pkg::t_out_item o_data
);
    import vcfcp_pkg::*;

    localparam int CNT_W = $clog2(2 * FRAME_WORDS_MAX + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(2 * FRAME_WORDS_MAX);

    logic              r_active;
    logic [CH_W-1:0]   r_granted;
    logic [CNT_W-1:0]  r_count;
    logic [HALF_W-1:0] r_pending;

    logic              n_active;
    logic [CH_W-1:0]   n_granted;
    logic [CNT_W-1:0]  n_count;
    logic [HALF_W-1:0] n_pending;

    logic              in_accept;
    logic [HALF_W-1:0] ch_data;
    logic              ch_valid;
    logic              ch_eof;
    logic              ch_eofe;
    logic              has_room;
    logic [CNT_W-1:0]  cnt_after;
    t_out_item         result;

    assign in_accept = i_valid && !o_stall;

    always_comb begin
        unique case (r_granted)
            2'd0:    ch_data = i_data.data_ch0;
            2'd1:    ch_data = i_data.data_ch1;
            2'd2:    ch_data = i_data.data_ch2;
            default: ch_data = i_data.data_ch3;
        endcase
    end

    assign ch_valid  = i_data.valid_mask[r_granted];
    assign ch_eof    = i_data.eof_mask[r_granted];
    assign ch_eofe   = i_data.eofe_mask[r_granted];
    assign has_room  = r_count < CAP;
    assign cnt_after = has_room ? r_count + CNT_W'(1) : r_count;

    always_comb begin
        n_active  = r_active;
        n_granted = r_granted;
        n_count   = r_count;
        n_pending = r_pending;
        result    = '0;
        if (i_data.reset_request) begin
            n_active  = 1'b0;
            n_granted = '0;
            n_count   = '0;
            n_pending = '0;
        end else if (!r_active) begin
            n_count   = '0;
            n_pending = '0;
            priority if (i_data.valid_mask[0]) begin
                n_active         = 1'b1;
                n_granted        = CH_W'(0);
                result.sof_error = !i_data.sof_mask[0];
            end else if (i_data.valid_mask[1]) begin
                n_active         = 1'b1;
                n_granted        = CH_W'(1);
                result.sof_error = !i_data.sof_mask[1];
            end else if (i_data.valid_mask[2]) begin
                n_active         = 1'b1;
                n_granted        = CH_W'(2);
                result.sof_error = !i_data.sof_mask[2];
            end else if (i_data.valid_mask[3]) begin
                n_active         = 1'b1;
                n_granted        = CH_W'(3);
                result.sof_error = !i_data.sof_mask[3];
            end
        end else if (ch_valid) begin
            if (has_room) begin
                n_count = cnt_after;
                if (!r_count[0]) begin
                    n_pending = ch_data;
                    if (ch_eof) begin
                        result.word_valid = 1'b1;
                        result.word_index = WORD_INDEX_W'(r_count >> 1);
                        result.word_data  = {{(WORD_W-HALF_W){1'b0}}, ch_data};
                    end
                end else begin
                    result.word_valid = 1'b1;
                    result.word_index = WORD_INDEX_W'(r_count >> 1);
                    result.word_data  = {ch_data, r_pending};
                end
            end
            if (ch_eof) begin
                result.frame_done    = 1'b1;
                result.frame_channel = r_granted;
                result.frame_words   = FRAME_WORDS_W'(cnt_after >> 1);
                result.frame_error   = ch_eofe || cnt_after[0];
                n_active  = 1'b0;
                n_count   = '0;
                n_pending = '0;
            end
        end
        result.ready_mask = n_active ? (NUM_CH'(1) << n_granted) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_granted <= '0;
            r_count   <= '0;
            r_pending <= '0;
        end else if (in_accept) begin
            r_active  <= n_active;
            r_granted <= n_granted;
            r_count   <= n_count;
            r_pending <= n_pending;
        end
    end

    vcfcp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (result),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== sv/vcfcp_skid.sv =====
// vcfcp_skid: result register with one skid entry for the result channel.
// Depends on vcfcp_pkg for the result transaction type.
module vcfcp_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  vcfcp_pkg::t_out_item i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output vcfcp_pkg::t_out_item o_data
);
    import vcfcp_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      in_take;
    logic      out_free;

    assign in_take  = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_take;
                end
            end else if (in_take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_take) begin
                r_out <= i_data;
            end
        end else if (in_take) begin
            r_skid <= i_data;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
